// ----- design/assert_macros.svh -----
// Assertion macros shared by the list engine RTL.
// Depends on clk and arst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/ile_pkg.sv -----
// Shared constants and types for the indexed list engine.
// No dependencies.
package ile_pkg;

	// Default sizing
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ITEM_WIDTH = 32;

	// Fixed field widths on the channels
	localparam int MODE_W  = 3;
	localparam int POS_W   = 7;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd4;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BOUNDS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	// Operation broadcast to every cell in the row
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_REM  = 2'd2,
		CELL_SET  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     rd;
	} cell_cmd_t;

endpackage

// ----- design/ile_req_if.sv -----
// Request channel of the list engine: valid/ready plus request payload.
// Depends on ile_pkg.
interface ile_req_if;
	logic                        valid;
	logic                        ready;
	logic [ile_pkg::MODE_W-1:0]  mode;
	logic [ile_pkg::POS_W-1:0]   position;
	logic [ile_pkg::WORD_W-1:0]  item_in;

	modport source (output valid, output mode, output position, output item_in, input ready);
	modport sink   (input valid, input mode, input position, input item_in, output ready);
endinterface

// ----- design/ile_rsp_if.sv -----
// Response channel of the list engine: valid/ready plus result payload.
// Depends on ile_pkg.
interface ile_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ile_pkg::WORD_W-1:0]  item_out;
	logic [ile_pkg::STAT_W-1:0]  status;
	logic [ile_pkg::COUNT_W-1:0] count;

	modport source (output valid, output item_out, output status, output count, input ready);
	modport sink   (input valid, input item_out, input status, input count, output ready);
endinterface

// ----- design/ile_cell.sv -----
// One storage cell of the list row: holds a single entry, shifts to/from neighbours.
// Depends on ile_pkg.
module ile_cell #(
	parameter int CAPACITY   = ile_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = ile_pkg::DEF_ITEM_WIDTH,
	parameter int INDEX      = 0
) (
	input  logic                         clk,
	input  ile_pkg::cell_cmd_t           cmd,
	input  logic [$clog2(CAPACITY)-1:0]  tgt,
	input  logic [ITEM_WIDTH-1:0]        item,
	input  logic [ITEM_WIDTH-1:0]        left,
	input  logic [ITEM_WIDTH-1:0]        right,
	output logic [ITEM_WIDTH-1:0]        data,
	output logic [ITEM_WIDTH-1:0]        hit
);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [ITEM_WIDTH-1:0] data_q;
	logic [ITEM_WIDTH-1:0] hit_q;
	logic [ITEM_WIDTH-1:0] data_d;

	// Next entry value for the broadcast operation
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			ile_pkg::CELL_INS: begin
				if (MY_IDX > tgt) begin
					data_d = left;
				end else if (MY_IDX == tgt) begin
					data_d = item;
				end
			end
			ile_pkg::CELL_REM: begin
				if (MY_IDX >= tgt) begin
					data_d = right;
				end
			end
			ile_pkg::CELL_SET: begin
				if (MY_IDX == tgt) begin
					data_d = item;
				end
			end
			default: data_d = data_q;
		endcase
	end

	// Entry store; read tap holds the pre-update word of the addressed cell, else zero
	always_ff @(posedge clk) begin
		data_q <= data_d;
		hit_q  <= (cmd.rd && (MY_IDX == tgt)) ? data_q : '0;
	end

	assign data = data_q;
	assign hit  = hit_q;
endmodule

// ----- design/ile_merge.sv -----
// Registered OR tree that gathers the read taps of all cells into one word.
// Depends on ile_pkg for default sizing.
module ile_merge #(
	parameter int CAPACITY   = ile_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = ile_pkg::DEF_ITEM_WIDTH
) (
	input  logic                  clk,
	input  logic                  capture,
	input  logic [ITEM_WIDTH-1:0] hits [CAPACITY],
	output logic [ITEM_WIDTH-1:0] merged
);
	localparam int GROUP  = 8;
	localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

	logic [ITEM_WIDTH-1:0] group_d [NGROUP];
	logic [ITEM_WIDTH-1:0] group_q [NGROUP];

	// First level: OR within each group of eight taps
	always_comb begin
		for (int j = 0; j < NGROUP; j++) begin
			group_d[j] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (j * GROUP + k < CAPACITY) begin
					group_d[j] = group_d[j] | hits[j * GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			group_q <= group_d;
		end
	end

	// Second level: OR across the registered groups
	always_comb begin
		merged = '0;
		for (int j = 0; j < NGROUP; j++) begin
			merged = merged | group_q[j];
		end
	end
endmodule

// ----- design/indexed_list_engine.sv -----
// Top level of the indexed list engine: request decode, cell row, read merge, output register.
// Depends on ile_pkg, ile_req_if, ile_rsp_if, ile_cell, ile_merge, assert_macros.svh.
//
//  channel | dir | payload                       | transfer when
//  --------+-----+-------------------------------+--------------------
//  req     | in  | mode, position, item_in       | req.valid && req.ready
//  rsp     | out | item_out, status, count       | rsp.valid && rsp.ready
//
// A result reaches the output register through these registers in order: the cells update
// and latch their read taps at the transfer edge, the first OR level is registered in the
// gather state and the result is loaded in the merge state. The next request is taken only
// after that load, so the engine does not accept a new request while one is in flight.
// A stalled result holds the following request in its merge step until rsp drains.
// Reset clears the live count and control only; entries are not cleared and need no sweep.
`include "assert_macros.svh"

module indexed_list_engine #(
	parameter int CAPACITY   = ile_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = ile_pkg::DEF_ITEM_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	ile_req_if.sink         req,
	ile_rsp_if.source       rsp
);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_GATHER = 3'b010,
		ST_MERGE  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                live_q;
	logic [CNT_W-1:0]                live_d;
	logic [ile_pkg::STAT_W-1:0]      stat_d;
	logic [ile_pkg::STAT_W-1:0]      status_s1;
	logic [ile_pkg::COUNT_W-1:0]     count_s1;
	logic                            rsp_valid_q;
	logic [ile_pkg::WORD_W-1:0]      item_out_q;
	logic [ile_pkg::STAT_W-1:0]      status_q;
	logic [ile_pkg::COUNT_W-1:0]     count_q;

	ile_pkg::cell_cmd_t              cmd;
	ile_pkg::cell_cmd_t              cmd_d;
	logic [IDX_W-1:0]                tgt;
	logic [IDX_W-1:0]                tgt_d;
	logic [ITEM_WIDTH-1:0]           item;
	logic [CMP_W-1:0]                pos_x;
	logic [CMP_W-1:0]                cnt_x;
	logic                            fire;
	logic                            load;
	logic [ITEM_WIDTH-1:0]           data_w [CAPACITY];
	logic [ITEM_WIDTH-1:0]           hit_w  [CAPACITY];
	logic [ITEM_WIDTH-1:0]           merged;

	assign req.ready = (state_q == ST_IDLE);
	assign fire      = req.valid && req.ready;
	assign load      = (state_q == ST_MERGE) && (!rsp_valid_q || rsp.ready);

	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(live_q);
	assign item  = ITEM_WIDTH'(req.item_in);

	// Request decode: bounds and fullness checks, cell operation and new count
	always_comb begin
		cmd_d  = '{op: ile_pkg::CELL_HOLD, rd: 1'b0};
		tgt_d  = IDX_W'(req.position);
		stat_d = ile_pkg::STAT_BOUNDS;
		live_d = live_q;
		case (req.mode)
			ile_pkg::MODE_INSERT: begin
				if (pos_x > cnt_x) begin
					stat_d = ile_pkg::STAT_BOUNDS;
				end else if (live_q == CNT_FULL) begin
					stat_d = ile_pkg::STAT_FULL;
				end else begin
					stat_d    = ile_pkg::STAT_DONE;
					cmd_d.op  = ile_pkg::CELL_INS;
					live_d    = live_q + CNT_W'(1);
				end
			end
			ile_pkg::MODE_REMOVE: begin
				if (pos_x < cnt_x) begin
					stat_d   = ile_pkg::STAT_DONE;
					cmd_d.op = ile_pkg::CELL_REM;
					cmd_d.rd = 1'b1;
					live_d   = live_q - CNT_W'(1);
				end
			end
			ile_pkg::MODE_SET: begin
				if (pos_x < cnt_x) begin
					stat_d   = ile_pkg::STAT_DONE;
					cmd_d.op = ile_pkg::CELL_SET;
				end
			end
			ile_pkg::MODE_GET: begin
				if (pos_x < cnt_x) begin
					stat_d   = ile_pkg::STAT_DONE;
					cmd_d.rd = 1'b1;
				end
			end
			ile_pkg::MODE_APPEND: begin
				tgt_d = IDX_W'(live_q);
				if (live_q == CNT_FULL) begin
					stat_d = ile_pkg::STAT_FULL;
				end else begin
					stat_d   = ile_pkg::STAT_DONE;
					cmd_d.op = ile_pkg::CELL_INS;
					live_d   = live_q + CNT_W'(1);
				end
			end
			ile_pkg::MODE_POP: begin
				tgt_d = IDX_W'(live_q - CNT_W'(1));
				if (live_q != '0) begin
					stat_d   = ile_pkg::STAT_DONE;
					cmd_d.op = ile_pkg::CELL_REM;
					cmd_d.rd = 1'b1;
					live_d   = live_q - CNT_W'(1);
				end
			end
			default: stat_d = ile_pkg::STAT_BOUNDS;
		endcase
	end

	// Broadcast only on a transfer
	assign cmd = fire ? cmd_d : ile_pkg::cell_cmd_t'{op: ile_pkg::CELL_HOLD, rd: 1'b0};
	assign tgt = tgt_d;

	// Row of cells, each wired to its neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_w;
		logic [ITEM_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = data_w[i+1];
		end
		ile_cell #(
			.CAPACITY   (CAPACITY),
			.ITEM_WIDTH (ITEM_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.tgt   (tgt),
			.item  (item),
			.left  (left_w),
			.right (right_w),
			.data  (data_w[i]),
			.hit   (hit_w[i])
		);
	end

	ile_merge #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_merge (
		.clk     (clk),
		.capture (state_q == ST_GATHER),
		.hits    (hit_w),
		.merged  (merged)
	);

	// Control: sequencer and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						state_q <= ST_GATHER;
						live_q  <= live_d;
					end
				end
				ST_GATHER: state_q <= ST_MERGE;
				ST_MERGE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Status and count travel alongside the read
	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= stat_d;
			count_s1  <= ile_pkg::COUNT_W'(live_d);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_out_q <= ile_pkg::WORD_W'(merged);
			status_q   <= status_s1;
			count_q    <= count_s1;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.item_out = item_out_q;
	assign rsp.status   = status_q;
	assign rsp.count    = count_q;

	// Checks
	`ASSERT_CLK(a_count_in_range, live_q <= CNT_FULL, "live count above capacity")
	`ASSERT_CLK(a_refused_keeps_count, (fire && stat_d != ile_pkg::STAT_DONE) |=> (live_q == $past(live_q)), "refused request changed the count")
	`ASSERT_CLK(a_load_from_merge, $rose(rsp_valid_q) |-> ($past(state_q) == ST_MERGE), "result shown without a merge step")
	`ASSERT_NEVER(a_refused_zero_item, rsp_valid_q && (status_q != ile_pkg::STAT_DONE) && (item_out_q != '0), "refused result carries a nonzero item")
endmodule

// ----- tb/tb_indexed_list_engine.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_engine: a directed script, then random traffic.
// Depends on ile_pkg, ile_req_if, ile_rsp_if and the engine RTL.
module tb_indexed_list_engine;

	localparam int CAPACITY     = ile_pkg::DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_GAP      = 16;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 2000;
	localparam int REPORT_MAX   = 10;

	// Mode codes the engine does not implement
	localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		logic [ile_pkg::WORD_W-1:0]  item_out;
		logic [ile_pkg::STAT_W-1:0]  status;
		logic [ile_pkg::COUNT_W-1:0] count;
	} list_reply_t;

	typedef struct packed {
		logic [ile_pkg::MODE_W-1:0] mode;
		logic [ile_pkg::POS_W-1:0]  position;
		logic [ile_pkg::WORD_W-1:0] word;
	} list_req_t;

	// One script row; rows with reps above one draw a fresh random word each time
	typedef struct packed {
		logic [ile_pkg::MODE_W-1:0] mode;
		logic [ile_pkg::POS_W-1:0]  position;
		logic [ile_pkg::WORD_W-1:0] word;
		int                         reps;
		bit                         typed;
		list_reply_t                want;
	} script_row_t;

	localparam script_row_t SCRIPT [27] = '{
		'{ile_pkg::MODE_GET,    7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}},
		'{ile_pkg::MODE_REMOVE, 7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}},
		'{ile_pkg::MODE_POP,    7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}},
		'{ile_pkg::MODE_SET,    7'd0,   32'hFFFF_FFFF, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}},
		'{ile_pkg::MODE_INSERT, 7'd1,   32'h0000_0001, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}},
		'{ile_pkg::MODE_INSERT, 7'd0,   32'hFFFF_FFFF, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd1}},
		'{ile_pkg::MODE_APPEND, 7'd127, 32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd2}},
		'{ile_pkg::MODE_INSERT, 7'd1,   32'hA5A5_5A5A, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd3}},
		'{ile_pkg::MODE_GET,    7'd1,   32'h0000_0000, 1,  1'b1,
			'{32'hA5A5_5A5A, ile_pkg::STAT_DONE,   7'd3}},
		'{ile_pkg::MODE_SET,    7'd2,   32'h1234_5678, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd3}},
		'{ile_pkg::MODE_GET,    7'd2,   32'h0000_0000, 1,  1'b1,
			'{32'h1234_5678, ile_pkg::STAT_DONE,   7'd3}},
		'{MODE_SPARE6,          7'd0,   32'hFFFF_FFFF, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd3}},
		'{MODE_SPARE7,          7'd127, 32'hFFFF_FFFF, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd3}},
		'{ile_pkg::MODE_GET,    7'd127, 32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd3}},
		'{ile_pkg::MODE_REMOVE, 7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'hFFFF_FFFF, ile_pkg::STAT_DONE,   7'd2}},
		'{ile_pkg::MODE_POP,    7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'h1234_5678, ile_pkg::STAT_DONE,   7'd1}},
		'{ile_pkg::MODE_APPEND, 7'd0,   32'h0000_0000, 63, 1'b0,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd0}},
		'{ile_pkg::MODE_APPEND, 7'd0,   32'h0000_0001, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_FULL,   7'd64}},
		'{ile_pkg::MODE_INSERT, 7'd0,   32'h0000_0001, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_FULL,   7'd64}},
		'{ile_pkg::MODE_INSERT, 7'd64,  32'h0000_0001, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_FULL,   7'd64}},
		'{ile_pkg::MODE_INSERT, 7'd65,  32'h0000_0001, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd64}},
		'{ile_pkg::MODE_SET,    7'd63,  32'hFFFF_FFFF, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd64}},
		'{ile_pkg::MODE_GET,    7'd63,  32'h0000_0000, 1,  1'b1,
			'{32'hFFFF_FFFF, ile_pkg::STAT_DONE,   7'd64}},
		'{ile_pkg::MODE_REMOVE, 7'd63,  32'h0000_0000, 1,  1'b1,
			'{32'hFFFF_FFFF, ile_pkg::STAT_DONE,   7'd63}},
		'{ile_pkg::MODE_REMOVE, 7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'hA5A5_5A5A, ile_pkg::STAT_DONE,   7'd62}},
		'{ile_pkg::MODE_POP,    7'd0,   32'h0000_0000, 62, 1'b0,
			'{32'h0000_0000, ile_pkg::STAT_DONE,   7'd0}},
		'{ile_pkg::MODE_POP,    7'd0,   32'h0000_0000, 1,  1'b1,
			'{32'h0000_0000, ile_pkg::STAT_BOUNDS, 7'd0}}
	};

	logic clk;
	logic arst_n;

	ile_req_if req_ch();
	ile_rsp_if rsp_ch();

	indexed_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list
	logic [ile_pkg::WORD_W-1:0] shadow_words [CAPACITY];
	int unsigned                shadow_len;

	list_reply_t pending_replies [$];
	int          fault_count;
	int          send_burst;
	int          recv_burst;
	bit          growing;
	bit          hold_off_armed;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Open a slot at pos and write the word there
	function automatic logic [ile_pkg::STAT_W-1:0] shadow_insert(input int unsigned pos,
			input logic [ile_pkg::WORD_W-1:0] word);
		if (pos > shadow_len)
			return ile_pkg::STAT_BOUNDS;
		if (shadow_len >= CAPACITY)
			return ile_pkg::STAT_FULL;
		for (int unsigned i = shadow_len; i > pos; i--)
			shadow_words[i] = shadow_words[i - 1];
		shadow_words[pos] = word;
		shadow_len++;
		return ile_pkg::STAT_DONE;
	endfunction

	// Take the word at pos out and close the gap
	function automatic logic [ile_pkg::STAT_W-1:0] shadow_remove(input int unsigned pos,
			output logic [ile_pkg::WORD_W-1:0] word);
		word = '0;
		if (pos >= shadow_len)
			return ile_pkg::STAT_BOUNDS;
		word = shadow_words[pos];
		for (int unsigned i = pos; i + 1 < shadow_len; i++)
			shadow_words[i] = shadow_words[i + 1];
		shadow_len--;
		return ile_pkg::STAT_DONE;
	endfunction

	// Apply one request to the shadow list and return the reply it should give
	function automatic list_reply_t list_apply(input list_req_t r);
		list_reply_t res;
		int unsigned pos;
		pos = r.position;
		res.item_out = '0;
		res.status = ile_pkg::STAT_DONE;
		case (r.mode)
			ile_pkg::MODE_INSERT: res.status = shadow_insert(pos, r.word);
			ile_pkg::MODE_APPEND: res.status = shadow_insert(shadow_len, r.word);
			ile_pkg::MODE_REMOVE: res.status = shadow_remove(pos, res.item_out);
			ile_pkg::MODE_POP: begin
				if (shadow_len == 0)
					res.status = ile_pkg::STAT_BOUNDS;
				else
					res.status = shadow_remove(shadow_len - 1, res.item_out);
			end
			ile_pkg::MODE_SET: begin
				if (pos >= shadow_len)
					res.status = ile_pkg::STAT_BOUNDS;
				else
					shadow_words[pos] = r.word;
			end
			ile_pkg::MODE_GET: begin
				if (pos >= shadow_len)
					res.status = ile_pkg::STAT_BOUNDS;
				else
					res.item_out = shadow_words[pos];
			end
			default: res.status = ile_pkg::STAT_BOUNDS;
		endcase
		res.count = ile_pkg::COUNT_W'(shadow_len);
		return res;
	endfunction

	// Idle cycles before the next transfer; occasional bursts with no idling at all
	function automatic int pick_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(20, 40);
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Random request biased so the list swings between empty and full
	function automatic list_req_t pick_request();
		list_req_t r;
		int unsigned roll;
		int unsigned top;
		bit adds;
		if (shadow_len == CAPACITY)
			growing = 1'b0;
		else if (shadow_len == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 49) == 0)
			growing = ~growing;
		roll = $urandom_range(0, 99);
		adds = growing ? (roll < 80) : (roll >= 80);
		if (roll < 3)
			r.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
		else if (roll < 15)
			r.mode = ile_pkg::MODE_SET;
		else if (roll < 28)
			r.mode = ile_pkg::MODE_GET;
		else if (adds)
			r.mode = $urandom_range(0, 1) ? ile_pkg::MODE_APPEND : ile_pkg::MODE_INSERT;
		else
			r.mode = $urandom_range(0, 1) ? ile_pkg::MODE_POP : ile_pkg::MODE_REMOVE;
		// Legal slot most of the time, then the edges, then anything
		top = (r.mode == ile_pkg::MODE_INSERT) ? shadow_len :
			((shadow_len == 0) ? 0 : shadow_len - 1);
		roll = $urandom_range(0, 9);
		if (roll < 8)
			r.position = ile_pkg::POS_W'($urandom_range(0, top));
		else if (roll == 8)
			r.position = ile_pkg::POS_W'(shadow_len + $urandom_range(0, 1));
		else
			r.position = ile_pkg::POS_W'($urandom_range(0, 127));
		case ($urandom_range(0, 15))
			0: r.word = '0;
			1: r.word = '1;
			default: r.word = $urandom;
		endcase
		return r;
	endfunction

	// Offer one request, wait for its transfer and log what it should return
	task automatic send_request(input list_req_t r, input bit typed, input list_reply_t want);
		list_reply_t predicted;
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= r.mode;
		req_ch.position <= r.position;
		req_ch.item_in  <= r.word;
		do @(posedge clk); while (!req_ch.ready);
		predicted = list_apply(r);
		pending_replies.push_back(typed ? want : predicted);
	endtask

	// Response side: random stalls, one long hold-off when armed
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = pick_gap(recv_burst);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Compare every response transfer with the oldest outstanding reply
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected reply: item_out=%h status=%0d count=%0d",
						rsp_ch.item_out, rsp_ch.status, rsp_ch.count);
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.item_out !== want.item_out || rsp_ch.status !== want.status ||
						rsp_ch.count !== want.count) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("reply mismatch: expected item_out=%h status=%0d count=%0d,",
							want.item_out, want.status, want.count,
							" got item_out=%h status=%0d count=%0d",
							rsp_ch.item_out, rsp_ch.status, rsp_ch.count);
				end
			end
		end
	end

	// Watchdog: too long without any transfer on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// Reset, directed script, random traffic, drain and verdict
	initial begin
		list_req_t r;
		fault_count    = 0;
		send_burst     = 0;
		recv_burst     = 0;
		growing        = 1'b1;
		hold_off_armed = 1'b0;
		shadow_len     = 0;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= ile_pkg::MODE_INSERT;
		req_ch.position <= '0;
		req_ch.item_in  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			for (int k = 0; k < SCRIPT[i].reps; k++) begin
				r.mode = SCRIPT[i].mode;
				r.position = SCRIPT[i].position;
				r.word = (SCRIPT[i].reps > 1) ? ile_pkg::WORD_W'($urandom) : SCRIPT[i].word;
				send_request(r, SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Long receiver hold-off while the sender keeps pushing, so the engine backs up
			if (n == 100) begin
				hold_off_armed = 1'b1;
				send_burst = 40;
			end
			// Sender stops until every outstanding reply is back
			if (n == 200) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_replies.size() != 0);
			end
			send_request(pick_request(), 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		do @(posedge clk); while (pending_replies.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_count += pending_replies.size();
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
